FILE: design/roi_scan_heatmap_sequencer_core_assert.svh
// assertion macros for the roi scan sequencer
`ifndef ROI_SCAN_HEATMAP_SEQUENCER_CORE_ASSERT_SVH
`define ROI_SCAN_HEATMAP_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define RSHS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rshs assertion failed");

// next-cycle implication
`define RSHS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rshs assertion failed");

`endif

FILE: design/rshs_pkg.sv
// types, constants and lookup functions for the roi scan sequencer
`default_nettype none

package rshs_pkg;

   localparam int unsigned MM_W   = 16;
   localparam int unsigned MIN_W  = 12;
   localparam int unsigned POS_W  = 8;
   localparam int unsigned AXIS_W = 4;
   localparam int unsigned GRID_W = 5;
   localparam int unsigned HEAT_W = 8;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned SPAD_W = 8;
   localparam int unsigned HEAT_STEPS = 12;

   typedef enum logic [MODE_W-1:0] {
      MODE_GRID16 = 2'd0,
      MODE_GRID8  = 2'd1,
      MODE_GRID4  = 2'd2,
      MODE_GRID1  = 2'd3
   } mode_type;

   localparam mode_type RESET_MODE = MODE_GRID8;

   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;

   localparam logic [MM_W-1:0]   VALID_LIMIT_MM    = 16'd4000;
   localparam logic [SPAD_W-1:0] FULL_FRAME_CENTER = 8'd199;
   localparam logic [SPAD_W-1:0] SPAD_UPPER_BASE   = 8'd128;
   localparam logic [SPAD_W-1:0] SPAD_LOWER_BASE   = 8'd127;
   localparam logic [AXIS_W-1:0] AXIS_GRID8_BASE   = 4'd4;

   localparam logic [MM_W-1:0] HEAT_BOUND [HEAT_STEPS] = '{
      16'd100, 16'd200, 16'd300, 16'd450, 16'd650, 16'd900,
      16'd1200, 16'd1550, 16'd1950, 16'd2350, 16'd2700, 16'd3000};

   localparam logic [HEAT_W-1:0] HEAT_VALUE [HEAT_STEPS+1] = '{
      8'd255, 8'd230, 8'd205, 8'd182, 8'd162, 8'd145, 8'd130,
      8'd118, 8'd108, 8'd100, 8'd94, 8'd90, 8'd88};

   // spad axis positions of the 4x4 grid
   localparam logic [AXIS_W-1:0] AXIS_GRID4 [4] = '{4'd2, 4'd6, 4'd9, 4'd13};

   typedef struct packed {
      logic [POS_W-1:0]  cell_index;
      logic [AXIS_W-1:0] cell_x;
      logic [AXIS_W-1:0] cell_y;
      logic [HEAT_W-1:0] intensity;
      logic              distance_valid;
      logic [MIN_W-1:0]  cycle_min_mm;
      logic              cycle_min_valid;
      logic [SPAD_W-1:0] next_roi_center;
      logic [GRID_W-1:0] roi_size;
      logic              scan_wrapped;
   } rsp_type;

   function automatic logic [GRID_W-1:0] grid_of(input mode_type m);
      logic [GRID_W-1:0] g;
      case (m)
         MODE_GRID16: g = 5'd16;
         MODE_GRID8:  g = 5'd8;
         MODE_GRID4:  g = 5'd4;
         MODE_GRID1:  g = 5'd1;
         default:     g = 5'd1;
      endcase
      return g;
   endfunction

   function automatic logic [POS_W-1:0] last_pos(input mode_type m);
      logic [POS_W-1:0] p;
      case (m)
         MODE_GRID16: p = 8'd255;
         MODE_GRID8:  p = 8'd63;
         MODE_GRID4:  p = 8'd15;
         MODE_GRID1:  p = 8'd0;
         default:     p = 8'd0;
      endcase
      return p;
   endfunction

   function automatic logic [AXIS_W-1:0] cell_x_of(input mode_type m,
                                                   input logic [POS_W-1:0] pos);
      logic [AXIS_W-1:0] x;
      case (m)
         MODE_GRID16: x = pos[3:0];
         MODE_GRID8:  x = {1'b0, pos[2:0]};
         MODE_GRID4:  x = {2'b00, pos[1:0]};
         MODE_GRID1:  x = '0;
         default:     x = '0;
      endcase
      return x;
   endfunction

   function automatic logic [AXIS_W-1:0] cell_y_of(input mode_type m,
                                                   input logic [POS_W-1:0] pos);
      logic [AXIS_W-1:0] y;
      case (m)
         MODE_GRID16: y = pos[7:4];
         MODE_GRID8:  y = {1'b0, pos[5:3]};
         MODE_GRID4:  y = {2'b00, pos[3:2]};
         MODE_GRID1:  y = '0;
         default:     y = '0;
      endcase
      return y;
   endfunction

   function automatic logic [HEAT_W-1:0] heat_for(input logic [MM_W-1:0] mm);
      logic [HEAT_W-1:0] h;
      h = HEAT_VALUE[HEAT_STEPS];
      // lowest matching step wins
      for (int k = HEAT_STEPS - 1; k >= 0; k--) begin
         if (mm <= HEAT_BOUND[k]) begin
            h = HEAT_VALUE[k];
         end
      end
      return h;
   endfunction

   function automatic logic [SPAD_W-1:0] spad_of(input logic [AXIS_W-1:0] cx,
                                                 input logic [AXIS_W-1:0] cy);
      logic [SPAD_W-1:0] col;
      logic [SPAD_W-1:0] s;
      col = {1'b0, cx, 3'b000};
      if (!cy[3]) begin
         s = SPAD_UPPER_BASE + col + {4'b0000, cy};
      end else begin
         s = SPAD_LOWER_BASE - col - {5'b00000, cy[2:0]};
      end
      return s;
   endfunction

   function automatic logic [SPAD_W-1:0] center_for(input mode_type m,
                                                    input logic [POS_W-1:0] pos);
      logic [SPAD_W-1:0] c;
      case (m)
         MODE_GRID8: begin
            c = spad_of(AXIS_GRID8_BASE + {1'b0, pos[2:0]},
                        AXIS_GRID8_BASE + {1'b0, pos[5:3]});
         end
         MODE_GRID4: begin
            c = spad_of(AXIS_GRID4[pos[1:0]], AXIS_GRID4[pos[3:2]]);
         end
         default: begin
            c = FULL_FRAME_CENTER;
         end
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/roi_scan_heatmap_sequencer_core.sv
// roi scan sequencer: cell tagging, heat lookup, cycle minimum, next roi centre
//
// req channel (req_valid/req_ready): one item is either a measurement
// (req_type 0, with req_distance_mm and req_timed_out) or a mode advance
// (req_type 1). rsp channel (rsp_valid/rsp_ready): exactly one result item
// per request item, in order.
// Each item passes an input register and a result register, in that
// order. One item per cycle is sustained while the receiver does not
// stall; the scan state is read and updated as an item moves from the
// input register into the result register.
// When the receiver stalls, the result register holds its item and the
// input register takes one more item; req_ready then drops until the
// result is taken.
// Reset (synchronous, active high) empties both registers, selects the
// 8x8 grid, sets the scan position to 0 and forgets the cycle minimum.
`default_nettype none
`include "roi_scan_heatmap_sequencer_core_assert.svh"

module roi_scan_heatmap_sequencer_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic                          req_type,
   input  wire logic [rshs_pkg::MM_W-1:0]     req_distance_mm,
   input  wire logic                          req_timed_out,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [rshs_pkg::POS_W-1:0]    rsp_cell_index,
   output      logic [rshs_pkg::AXIS_W-1:0]   rsp_cell_x,
   output      logic [rshs_pkg::AXIS_W-1:0]   rsp_cell_y,
   output      logic [rshs_pkg::HEAT_W-1:0]   rsp_intensity,
   output      logic                          rsp_distance_valid,
   output      logic [rshs_pkg::MIN_W-1:0]    rsp_cycle_min_mm,
   output      logic                          rsp_cycle_min_valid,
   output      logic [rshs_pkg::SPAD_W-1:0]   rsp_next_roi_center,
   output      logic [rshs_pkg::GRID_W-1:0]   rsp_roi_size,
   output      logic                          rsp_scan_wrapped
);

   import rshs_pkg::*;

   // input register
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_type_ff;
   logic [MM_W-1:0]   s1_mm_ff;
   logic              s1_tmo_ff;

   // scan state
   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [MIN_W-1:0]  min_ff, min_in;
   logic              seen_ff, seen_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept_req;
   logic              advance;
   logic              seen_base;
   logic              meas_valid;
   logic              wrapped;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept_req = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept_req) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      min_in     = min_ff;
      seen_in    = seen_ff;
      seen_base  = seen_ff;
      meas_valid = 1'b0;
      wrapped    = 1'b0;
      rsp_in     = '0;
      if (s1_type_ff == REQ_ADVANCE) begin
         mode_in = mode_type'(mode_ff + 2'd1);
         pos_in  = '0;
         seen_in = 1'b0;
      end else begin
         // a new scan cycle starts at position zero
         seen_base  = (pos_ff == '0) ? 1'b0 : seen_ff;
         meas_valid = !s1_tmo_ff && (s1_mm_ff != '0) && (s1_mm_ff < VALID_LIMIT_MM);
         seen_in    = seen_base;
         if (meas_valid && (!seen_base || (s1_mm_ff[MIN_W-1:0] < min_ff))) begin
            min_in  = s1_mm_ff[MIN_W-1:0];
            seen_in = 1'b1;
         end
         wrapped = (pos_ff == last_pos(mode_ff));
         pos_in  = wrapped ? '0 : pos_ff + 8'd1;
         rsp_in.cell_index     = pos_ff;
         rsp_in.cell_x         = cell_x_of(mode_ff, pos_ff);
         rsp_in.cell_y         = cell_y_of(mode_ff, pos_ff);
         rsp_in.intensity      = meas_valid ? heat_for(s1_mm_ff) : '0;
         rsp_in.distance_valid = meas_valid;
         rsp_in.scan_wrapped   = wrapped;
      end
      rsp_in.cycle_min_mm    = seen_in ? min_in : '0;
      rsp_in.cycle_min_valid = seen_in;
      rsp_in.next_roi_center = center_for(mode_in, pos_in);
      rsp_in.roi_size        = grid_of(mode_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= RESET_MODE;
         pos_ff       <= '0;
         min_ff       <= '0;
         seen_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff <= mode_in;
            pos_ff  <= pos_in;
            min_ff  <= min_in;
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_req) begin
         s1_type_ff <= req_type;
         s1_mm_ff   <= req_distance_mm;
         s1_tmo_ff  <= req_timed_out;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cell_index      = rsp_ff.cell_index;
   assign rsp_cell_x          = rsp_ff.cell_x;
   assign rsp_cell_y          = rsp_ff.cell_y;
   assign rsp_intensity       = rsp_ff.intensity;
   assign rsp_distance_valid  = rsp_ff.distance_valid;
   assign rsp_cycle_min_mm    = rsp_ff.cycle_min_mm;
   assign rsp_cycle_min_valid = rsp_ff.cycle_min_valid;
   assign rsp_next_roi_center = rsp_ff.next_roi_center;
   assign rsp_roi_size        = rsp_ff.roi_size;
   assign rsp_scan_wrapped    = rsp_ff.scan_wrapped;

   // scan position never leaves the current grid
   `RSHS_ASSERT_IMP(a_pos_in_grid, clock, reset, 1'b1, pos_ff <= last_pos(mode_ff))

   // a mode advance restarts the scan and forgets the minimum
   `RSHS_ASSERT_NXT(a_advance_restarts, clock, reset,
                    advance && (s1_type_ff == REQ_ADVANCE), (pos_ff == '0) && !seen_ff)

   // while a wrapping result waits, the state still sits at the grid start
   `RSHS_ASSERT_IMP(a_wrap_pos_zero, clock, reset,
                    rsp_valid_ff && rsp_ff.scan_wrapped, pos_ff == '0)

   // a reported minimum is always a valid distance
   `RSHS_ASSERT_IMP(a_min_in_range, clock, reset,
                    rsp_valid_ff && rsp_ff.cycle_min_valid,
                    (rsp_ff.cycle_min_mm != '0) && (rsp_ff.cycle_min_mm < 12'd4000))

endmodule

`default_nettype wire
